FILE: rtl/wsfe_pkg.sv
// Shared types and constants for the WebSocket masked frame encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsfe_pkg;

	localparam int unsigned LEN_W = 63;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned HDR_SH_W = 104;   // up to 13 header bytes after the first

	localparam logic [7:0]       HDR_BYTE0  = 8'h81;  // FIN + text opcode
	localparam logic [7:0]       MASK_BIT   = 8'h80;
	localparam logic [6:0]       LEN16_CODE = 7'd126;
	localparam logic [6:0]       LEN64_CODE = 7'd127;
	localparam logic [LEN_W-1:0] LEN16_MAX  = 63'd65535;
	localparam logic [LEN_W-1:0] LEN7_LIM   = 63'd126;

	localparam logic [3:0] REM_LEN7  = 4'd5;
	localparam logic [3:0] REM_LEN16 = 4'd7;
	localparam logic [3:0] REM_LEN64 = 4'd13;

	typedef enum logic [1:0] {
		CMD_HDR  = 2'd0,
		CMD_PAY  = 2'd1,
		CMD_DROP = 2'd2
	} cmd_kind_t;

	typedef enum logic [1:0] {
		LEN_7  = 2'd0,
		LEN_16 = 2'd1,
		LEN_64 = 2'd2
	} len_class_t;

	// one entry of the front-to-back queue
	typedef struct packed {
		cmd_kind_t         kind;
		len_class_t        lclass;
		logic [7:0]        data;     // masked payload byte
		logic              last;     // payload: final byte; header: empty frame
		logic [LEN_W-1:0]  len;
		logic [KEY_W-1:0]  key;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/wsfe_front.sv
// Front end: accepts input beats, tracks the open frame, masks payload bytes
// and emits one queue command per beat. Depends on wsfe_pkg.
`default_nettype none

module wsfe_front
	import wsfe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic               func,
	input  wire logic [LEN_W-1:0]   frame_length,
	input  wire logic [KEY_W-1:0]   key_word,
	input  wire logic [7:0]         payload_byte,
	output cmd_t                    cmd
);

	logic              frame_open_q;
	logic [1:0]        key_position_q;
	logic [LEN_W-1:0]  bytes_left_q;
	logic [KEY_W-1:0]  held_key_q;
	logic [7:0]        key_byte;
	logic              pay_last;

	always_comb begin
		unique case (key_position_q)
			2'd0:    key_byte = held_key_q[31:24];
			2'd1:    key_byte = held_key_q[23:16];
			2'd2:    key_byte = held_key_q[15:8];
			default: key_byte = held_key_q[7:0];
		endcase
	end

	assign pay_last = (bytes_left_q == LEN_W'(1));

	always_comb begin
		cmd.len    = frame_length;
		cmd.key    = key_word;
		cmd.data   = payload_byte ^ key_byte;
		cmd.lclass = LEN_64;
		if (frame_length < LEN7_LIM) begin
			cmd.lclass = LEN_7;
		end else if (frame_length <= LEN16_MAX) begin
			cmd.lclass = LEN_16;
		end
		if (!func) begin
			cmd.kind = CMD_HDR;
			cmd.last = (frame_length == '0);
		end else if (!frame_open_q) begin
			cmd.kind = CMD_DROP;
			cmd.last = 1'b0;
		end else begin
			cmd.kind = CMD_PAY;
			cmd.last = pay_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q   <= 1'b0;
			key_position_q <= '0;
		end else if (accept) begin
			if (!func) begin
				frame_open_q   <= (frame_length != '0);
				key_position_q <= '0;
			end else if (frame_open_q) begin
				frame_open_q   <= !pay_last;
				key_position_q <= key_position_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!func) begin
				bytes_left_q <= frame_length;
				held_key_q   <= key_word;
			end else if (frame_open_q) begin
				bytes_left_q <= bytes_left_q - LEN_W'(1);
			end
		end
	end

	// an open frame always has payload pending
	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> (bytes_left_q != '0))
		else $error("frame open with no bytes left");

endmodule

`default_nettype wire

FILE: rtl/wsfe_queue.sv
// Short command queue between front and back ends, flop based.
// Depends on wsfe_pkg for the command type.
`default_nettype none

module wsfe_queue
	import wsfe_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  cmd_t       wr_cmd,
	output logic       full,
	input  wire logic  pop,
	output cmd_t       rd_cmd,
	output logic       empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/wsfe_back.sv
// Back end: pops queue commands, serializes frame headers byte by byte and
// holds the output register. Depends on wsfe_pkg.
`default_nettype none

module wsfe_back
	import wsfe_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  cmd_t        cmd,
	input  wire logic   cmd_empty,
	output logic        cmd_pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        is_header,
	output logic        status
);

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 frame_end_q;
	logic                 is_header_q;
	logic                 status_q;
	logic                 busy_q;
	logic [3:0]           rem_q;
	logic                 zero_len_q;
	logic [HDR_SH_W-1:0]  sh_q;

	logic                 adv;
	logic                 load;
	logic [7:0]           nxt_byte;
	logic                 nxt_end;
	logic                 nxt_hdr;
	logic                 nxt_status;
	logic                 sh_load;
	logic [HDR_SH_W-1:0]  sh_init;
	logic [3:0]           rem_init;

	assign adv     = !out_valid_q || out_ready;
	assign cmd_pop = adv && !busy_q && !cmd_empty;
	assign load    = adv && (busy_q || !cmd_empty);
	assign sh_load = cmd_pop && (cmd.kind == CMD_HDR);

	// remaining header bytes after the first, top byte goes out first
	always_comb begin
		unique case (cmd.lclass)
			LEN_7: begin
				sh_init  = {MASK_BIT | {1'b0, cmd.len[6:0]}, cmd.key, 64'd0};
				rem_init = REM_LEN7;
			end
			LEN_16: begin
				sh_init  = {MASK_BIT | {1'b0, LEN16_CODE}, cmd.len[15:0], cmd.key, 48'd0};
				rem_init = REM_LEN16;
			end
			default: begin
				sh_init  = {MASK_BIT | {1'b0, LEN64_CODE}, 1'b0, cmd.len, cmd.key};
				rem_init = REM_LEN64;
			end
		endcase
	end

	always_comb begin
		nxt_byte   = sh_q[HDR_SH_W-1 -: 8];
		nxt_end    = (rem_q == 4'd1) && zero_len_q;
		nxt_hdr    = 1'b1;
		nxt_status = 1'b0;
		if (!busy_q) begin
			unique case (cmd.kind)
				CMD_HDR: begin
					nxt_byte = HDR_BYTE0;
					nxt_end  = 1'b0;
				end
				CMD_PAY: begin
					nxt_byte = cmd.data;
					nxt_end  = cmd.last;
					nxt_hdr  = 1'b0;
				end
				default: begin
					nxt_byte   = 8'd0;
					nxt_end    = 1'b0;
					nxt_hdr    = 1'b0;
					nxt_status = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			rem_q       <= '0;
		end else if (adv) begin
			out_valid_q <= load;
			if (busy_q) begin
				rem_q  <= rem_q - 4'd1;
				busy_q <= (rem_q != 4'd1);
			end else if (sh_load) begin
				rem_q  <= rem_init;
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= nxt_byte;
			frame_end_q <= nxt_end;
			is_header_q <= nxt_hdr;
			status_q    <= nxt_status;
		end
		if (adv && busy_q) begin
			sh_q <= sh_q << 8;
		end else if (sh_load) begin
			sh_q       <= sh_init;
			zero_len_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign is_header = is_header_q;
	assign status    = status_q;

	a_busy_has_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0))
		else $error("header sequencer busy with nothing left");

	a_drop_is_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (!is_header_q && !frame_end_q))
		else $error("dropped-byte beat marked as header or frame end");

endmodule

`default_nettype wire

FILE: rtl/websocket_masked_frame_encoder.sv
// Top level of the WebSocket client frame encoder; uses wsfe_pkg, wsfe_front,
// wsfe_queue and wsfe_back.
// An accepted item is registered in the queue, then popped into the back-end
// output register that drives m_tvalid.
// Payload beats sustain one per cycle while m_tready is high and no header is
// being serialized; start beats give 6, 8 or 14 bytes per 7-, 16-, 64-bit form.
// Reset: arst_n clears asynchronously; queue empty, no frame open, no output.
`default_nettype none

module websocket_masked_frame_encoder
	import wsfe_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,

	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [103:0]  s_tdata,   // [62:0] frame_length, [94:63] key_word,
	                                      // [102:95] payload_byte, [103] zero
	input  wire logic [0:0]    s_tuser,   // [0] func

	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata,   // [7:0] out_byte
	output logic               m_tlast,   // frame_end
	output logic [1:0]         m_tuser    // [0] is_header, [1] status
);

	// Front end classifies each beat and updates the frame state at accept
	// time, so payload masking never waits on header serialization. The
	// queue absorbs the multi-byte header work of start beats.

	logic  accept;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	cmd_t  front_cmd;
	cmd_t  back_cmd;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	wsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (s_tuser[0]),
		.frame_length (s_tdata[62:0]),
		.key_word     (s_tdata[94:63]),
		.payload_byte (s_tdata[102:95]),
		.cmd          (front_cmd)
	);

	wsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wr_cmd (front_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (back_cmd),
		.empty  (q_empty)
	);

	// Back end: header serializer plus the output register that decouples
	// downstream stalls from the queue.
	wsfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.frame_end (m_tlast),
		.is_header (m_tuser[0]),
		.status    (m_tuser[1])
	);

endmodule

`default_nettype wire
